// ===== design/dagb_pkg.sv =====
// Package for the dual armed gate buffer: field widths, trigger state codes,
// configuration register indexes and the per-tick trigger and channel functions.
// No dependencies.
package dagb_pkg;

  localparam int LEVEL_W  = 16;
  localparam int CFG_IDX_W = 2;

  typedef logic signed [LEVEL_W-1:0] level_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOW_THRESHOLD  = 2'd0,
    REG_HIGH_THRESHOLD = 2'd1
  } cfg_reg_t;

  localparam level_t LOW_THRESHOLD_RST  = 16'sd0;
  localparam level_t HIGH_THRESHOLD_RST = 16'sd1000;

  typedef enum logic [1:0] {
    TS_UNKNOWN = 2'd0,
    TS_LOW     = 2'd1,
    TS_HIGH    = 2'd2
  } trig_state_t;

  typedef struct packed {
    trig_state_t st;
    logic        rise;
  } trig_res_t;

  typedef struct packed {
    logic arm;
    logic out;
    logic pend;
  } chan_state_t;

  // Schmitt trigger step. The high test comes first from unknown and from low,
  // and only a low-to-high change reports a rising edge.
  function automatic trig_res_t trig_step(trig_state_t st, level_t level,
                                          level_t lo, level_t hi);
    trig_res_t res;
    res.st   = st;
    res.rise = 1'b0;
    case (st)
      TS_LOW: begin
        if (level >= hi) begin
          res.st   = TS_HIGH;
          res.rise = 1'b1;
        end
      end
      TS_HIGH: begin
        if (level <= lo) res.st = TS_LOW;
      end
      default: begin
        if (level >= hi) res.st = TS_HIGH;
        else if (level <= lo) res.st = TS_LOW;
      end
    endcase
    return res;
  endfunction

  // Gate handling for one channel after its arm flag has been updated.
  function automatic chan_state_t chan_step(logic gate, logic last, chan_state_t cs);
    chan_state_t res;
    res = cs;
    if (gate) begin
      res.out = res.arm;
    end else if (res.out) begin
      res.arm = 1'b0;
      res.out = 1'b0;
    end
    if (res.pend && last && !gate) begin
      res.arm  = 1'b1;
      res.pend = 1'b0;
    end
    return res;
  endfunction

endpackage

// ===== design/dagb_in_if.sv =====
// Input channel of the dual armed gate buffer: one sample tick per transaction.
// Depends on dagb_pkg.
interface dagb_in_if;
  logic            valid;
  logic            ready;
  dagb_pkg::level_t arm_one_level;
  dagb_pkg::level_t gate_one_level;
  dagb_pkg::level_t arm_two_level;
  dagb_pkg::level_t gate_two_level;
  logic            arm_one_connected;
  logic            gate_one_connected;
  logic            arm_two_connected;
  logic            gate_two_connected;

  modport source (output valid, arm_one_level, gate_one_level, arm_two_level,
                  gate_two_level, arm_one_connected, gate_one_connected,
                  arm_two_connected, gate_two_connected, input ready);
  modport sink (input valid, arm_one_level, gate_one_level, arm_two_level,
                gate_two_level, arm_one_connected, gate_one_connected,
                arm_two_connected, gate_two_connected, output ready);
endinterface

// ===== design/dagb_out_if.sv =====
// Result channel of the dual armed gate buffer: output levels and arm lights.
// No dependencies.
interface dagb_out_if;
  logic valid;
  logic ready;
  logic out_one_high;
  logic out_two_high;
  logic armed_one;
  logic armed_two;

  modport source (output valid, out_one_high, out_two_high, armed_one, armed_two,
                  input ready);
  modport sink (input valid, out_one_high, out_two_high, armed_one, armed_two,
                output ready);
endinterface

// ===== design/dagb_cfg_if.sv =====
// Configuration write channel of the dual armed gate buffer.
// Depends on dagb_pkg.
interface dagb_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [dagb_pkg::CFG_IDX_W-1:0]   index;
  dagb_pkg::level_t                 data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== design/dual_armed_gate_buffer.sv =====
// Dual armed gate buffer: two gate channels, each passing its gate only when armed.
// Usage:
//   in_ch  carries one sample tick per transaction: four signed millivolt levels
//          (arm and gate of both channels) and a patched flag for each jack.
//   out_ch returns one transaction per tick: both output levels and both arm lights.
//   cfg_ch writes the shared Schmitt thresholds (index 0 low, index 1 high); it is
//          always ready and is meant to be used only while the block is idle.
// A tick accepted into the input register is evaluated there by the trigger and
// channel logic, and its result lands in the result register, which drives out_ch,
// as soon as that register is empty or its transaction is being taken.
// Throughput is one tick per cycle while out_ch is not stalled, since the state
// update between those two registers is combinational.
// When the receiver stalls, the result register holds its transaction, the input
// register holds the next tick, and in_ch.ready drops once both are full.
// Reset (rst_n low, synchronous) empties both registers, sets all four triggers
// to unknown, clears every arm, pending, output and previous-gate flag, and loads
// the thresholds with 0 mV (low) and 1000 mV (high).
module dual_armed_gate_buffer (
  input  logic         clk,
  input  logic         rst_n,
  dagb_in_if.sink      in_ch,
  dagb_out_if.source   out_ch,
  dagb_cfg_if.sink     cfg_ch
);

  // Configuration registers.
  dagb_pkg::level_t low_thr_r;
  dagb_pkg::level_t high_thr_r;

  // Input register.
  logic             in_vld_r;
  dagb_pkg::level_t arm1_lvl_r, gate1_lvl_r, arm2_lvl_r, gate2_lvl_r;
  logic             arm1_con_r, gate1_con_r, arm2_con_r, gate2_con_r;

  // Block state.
  dagb_pkg::trig_state_t ts_r [4];
  dagb_pkg::trig_state_t ts_nxt [4];
  logic                  gate1_prev_r, gate2_prev_r;
  logic                  gate1_prev_nxt, gate2_prev_nxt;
  dagb_pkg::chan_state_t ch1_r, ch2_r, ch1_nxt, ch2_nxt;

  // Result register.
  logic out_vld_r;
  logic out1_r, out2_r, armed1_r, armed2_r;

  logic advance;
  logic in_take;

  assign advance = !out_vld_r || out_ch.ready;
  assign in_ch.ready = !in_vld_r || advance;
  assign in_take = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid        = out_vld_r;
  assign out_ch.out_one_high = out1_r;
  assign out_ch.out_two_high = out2_r;
  assign out_ch.armed_one    = armed1_r;
  assign out_ch.armed_two    = armed2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_thr_r  <= dagb_pkg::LOW_THRESHOLD_RST;
      high_thr_r <= dagb_pkg::HIGH_THRESHOLD_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        dagb_pkg::REG_LOW_THRESHOLD:  low_thr_r  <= cfg_ch.data;
        dagb_pkg::REG_HIGH_THRESHOLD: high_thr_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      arm1_lvl_r  <= in_ch.arm_one_level;
      gate1_lvl_r <= in_ch.gate_one_level;
      arm2_lvl_r  <= in_ch.arm_two_level;
      gate2_lvl_r <= in_ch.gate_two_level;
      arm1_con_r  <= in_ch.arm_one_connected;
      gate1_con_r <= in_ch.gate_one_connected;
      arm2_con_r  <= in_ch.arm_two_connected;
      gate2_con_r <= in_ch.gate_two_connected;
    end
  end

  // One tick of the trigger and channel logic on the held input.
  always_comb begin
    dagb_pkg::trig_res_t tr0, tr1, tr2, tr3;
    logic g1, g2;
    dagb_pkg::chan_state_t c1, c2;

    for (int i = 0; i < 4; i++) ts_nxt[i] = ts_r[i];
    c1 = ch1_r;
    c2 = ch2_r;

    tr1 = dagb_pkg::trig_step(ts_r[1], gate1_lvl_r, low_thr_r, high_thr_r);
    if (gate1_con_r) ts_nxt[1] = tr1.st;
    g1 = (ts_nxt[1] == dagb_pkg::TS_HIGH);

    tr3 = dagb_pkg::trig_step(ts_r[3], gate2_lvl_r, low_thr_r, high_thr_r);
    if (gate2_con_r) begin
      ts_nxt[3] = tr3.st;
      g2 = (tr3.st == dagb_pkg::TS_HIGH);
    end else begin
      g2 = g1;
    end

    tr0 = dagb_pkg::trig_step(ts_r[0], arm1_lvl_r, low_thr_r, high_thr_r);
    if (arm1_con_r) begin
      ts_nxt[0] = tr0.st;
      if (tr0.rise) begin
        if (!g1) c1.arm = 1'b1;
        else c1.pend = 1'b1;
      end
    end else begin
      c1.arm = 1'b0;
    end
    c1 = dagb_pkg::chan_step(g1, gate1_prev_r, c1);

    tr2 = dagb_pkg::trig_step(ts_r[2], arm2_lvl_r, low_thr_r, high_thr_r);
    if (arm2_con_r) begin
      ts_nxt[2] = tr2.st;
      if (tr2.rise) begin
        if (!g2) c2.arm = 1'b1;
        else c2.pend = 1'b1;
      end
    end else begin
      // An unpatched arm two copies channel one's flag after its update.
      c2.arm = c1.arm;
    end
    c2 = dagb_pkg::chan_step(g2, gate2_prev_r, c2);

    ch1_nxt        = c1;
    ch2_nxt        = c2;
    gate1_prev_nxt = g1;
    gate2_prev_nxt = g2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) ts_r[i] <= dagb_pkg::TS_UNKNOWN;
      gate1_prev_r <= 1'b0;
      gate2_prev_r <= 1'b0;
      ch1_r        <= '0;
      ch2_r        <= '0;
      out_vld_r    <= 1'b0;
    end else if (advance) begin
      out_vld_r <= in_vld_r;
      if (in_vld_r) begin
        for (int i = 0; i < 4; i++) ts_r[i] <= ts_nxt[i];
        gate1_prev_r <= gate1_prev_nxt;
        gate2_prev_r <= gate2_prev_nxt;
        ch1_r        <= ch1_nxt;
        ch2_r        <= ch2_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_vld_r) begin
      out1_r   <= ch1_nxt.out;
      out2_r   <= ch2_nxt.out;
      armed1_r <= ch1_nxt.arm;
      armed2_r <= ch2_nxt.arm;
    end
  end

endmodule

// ===== design/dagb_check.sv =====
// Port-level checks for the dual armed gate buffer, bound to the top level.
// Depends on dual_armed_gate_buffer and its result channel interface.
module dagb_check (
  input logic clk,
  input logic rst_n,
  input logic out_valid,
  input logic out_ready,
  input logic out_one_high,
  input logic out_two_high,
  input logic armed_one,
  input logic armed_two
);

  // The result channel is empty right after reset.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result transaction presented right after reset");

  // A stalled result transaction keeps its payload.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_one_high)
      && $stable(armed_one) && $stable(out_two_high) && $stable(armed_two))
    else $error("stalled result transaction changed");

  // An output can only be high while its channel is armed.
  a_out_one_armed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_one_high |-> armed_one)
    else $error("channel one output high while not armed");

  a_out_two_armed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_two_high |-> armed_two)
    else $error("channel two output high while not armed");

endmodule

bind dual_armed_gate_buffer dagb_check u_dagb_check (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_one_high (out_ch.out_one_high),
  .out_two_high (out_ch.out_two_high),
  .armed_one    (out_ch.armed_one),
  .armed_two    (out_ch.armed_two)
);

// ===== tb/dual_armed_gate_buffer_test.sv =====
// Testbench for dual_armed_gate_buffer: a directed stimulus table, then random sample
// ticks under several threshold settings, checked against a cycle-free model or typed results.
// Depends on dagb_pkg, dagb_in_if, dagb_out_if, dagb_cfg_if and the block itself.
module dual_armed_gate_buffer_test;
  timeunit 1ns;
  timeprecision 1ps;

  import dagb_pkg::*;

  localparam int TRIG_ARM1  = 0;
  localparam int TRIG_GATE1 = 1;
  localparam int TRIG_ARM2  = 2;
  localparam int TRIG_GATE2 = 3;
  localparam int LONG_STALL = 48;

  localparam level_t HI  = 16'sh7FFF;
  localparam level_t LO  = 16'sh8000;
  localparam level_t MID = 16'sd500;

  typedef struct packed {
    level_t arm_one;
    level_t gate_one;
    level_t arm_two;
    level_t gate_two;
    logic   arm_one_con;
    logic   gate_one_con;
    logic   arm_two_con;
    logic   gate_two_con;
  } tick_t;

  typedef struct packed {
    logic out_one;
    logic out_two;
    logic armed_one;
    logic armed_two;
  } result_t;

  typedef struct packed {
    tick_t   tick;
    logic    typed;
    result_t want;
  } dir_row_t;

  typedef struct packed {
    level_t lo;
    level_t hi;
    int     count;
    int     send_idle;
    int     recv_idle;
    logic   long_stall;
    logic   mid_drain;
  } phase_t;

  // Result fields: out_one, out_two, armed_one, armed_two. Rows with a typed
  // result are checked against that value; the others against the model.
  localparam dir_row_t DIRECTED_ROWS [21] = '{
    '{'{MID, MID, MID, MID, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b1, 4'b0000},
    '{'{MID, MID, MID, MID, 1'b1, 1'b1, 1'b1, 1'b1}, 1'b1, 4'b0000},
    '{'{HI, LO, HI, LO, 1'b1, 1'b1, 1'b1, 1'b1}, 1'b1, 4'b0000},
    '{'{LO, LO, LO, LO, 1'b1, 1'b1, 1'b1, 1'b1}, 1'b1, 4'b0000},
    '{'{HI, LO, HI, LO, 1'b1, 1'b1, 1'b1, 1'b1}, 1'b1, 4'b0011},
    '{'{HI, HI, HI, HI, 1'b1, 1'b1, 1'b1, 1'b1}, 1'b1, 4'b1111},
    '{'{HI, LO, HI, LO, 1'b1, 1'b1, 1'b1, 1'b1}, 1'b1, 4'b0000},
    '{'{LO, HI, LO, HI, 1'b1, 1'b1, 1'b1, 1'b1}, 1'b0, 4'b0000},
    '{'{HI, HI, HI, HI, 1'b1, 1'b1, 1'b1, 1'b1}, 1'b0, 4'b0000},
    '{'{HI, LO, HI, LO, 1'b1, 1'b1, 1'b1, 1'b1}, 1'b0, 4'b0000},
    '{'{HI, HI, HI, HI, 1'b1, 1'b1, 1'b1, 1'b1}, 1'b0, 4'b0000},
    '{'{HI, 16'sd0, HI, 16'sd0, 1'b1, 1'b1, 1'b1, 1'b1}, 1'b0, 4'b0000},
    '{'{LO, 16'sd1000, LO, 16'sd1000, 1'b1, 1'b1, 1'b1, 1'b1}, 1'b0, 4'b0000},
    '{'{HI, LO, HI, LO, 1'b1, 1'b1, 1'b1, 1'b0}, 1'b0, 4'b0000},
    '{'{HI, HI, HI, LO, 1'b1, 1'b1, 1'b1, 1'b0}, 1'b0, 4'b0000},
    '{'{LO, HI, HI, HI, 1'b1, 1'b1, 1'b0, 1'b1}, 1'b0, 4'b0000},
    '{'{HI, HI, HI, HI, 1'b0, 1'b1, 1'b0, 1'b1}, 1'b0, 4'b0000},
    '{'{LO, LO, LO, LO, 1'b0, 1'b0, 1'b1, 1'b1}, 1'b0, 4'b0000},
    '{'{HI, LO, HI, HI, 1'b1, 1'b0, 1'b1, 1'b1}, 1'b0, 4'b0000},
    '{'{16'sd999, 16'sd1, 16'sd999, 16'sd1, 1'b1, 1'b1, 1'b1, 1'b1}, 1'b0, 4'b0000},
    '{'{LO, LO, LO, LO, 1'b1, 1'b1, 1'b1, 1'b1}, 1'b0, 4'b0000}
  };

  // Threshold settings for the random part, including both extremes and crossed pairs.
  localparam phase_t PHASES [9] = '{
    '{16'sd0,     16'sd1000,  250, 30, 60, 1'b1, 1'b0},
    '{LO,         HI,         150, 30, 60, 1'b0, 1'b1},
    '{HI,         LO,         150, 30, 60, 1'b0, 1'b0},
    '{-16'sd500,  16'sd500,   250, 60, 30, 1'b0, 1'b1},
    '{16'sd100,   16'sd100,   150, 60, 30, 1'b0, 1'b0},
    '{LO,         LO,         100, 60, 30, 1'b0, 1'b0},
    '{HI,         HI,         100,  0,  0, 1'b0, 1'b0},
    '{16'sd0,     16'sd1000,  250,  0,  0, 1'b1, 1'b0},
    '{16'sd1000,  16'sd0,     200,  0,  0, 1'b0, 1'b0}
  };

  logic clk = 1'b0;
  logic rst_n;

  dagb_in_if  in_ch();
  dagb_out_if out_ch();
  dagb_cfg_if cfg_ch();

  dual_armed_gate_buffer u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Model state of the gate buffer.
  trig_state_t trig_q [4] = '{default: TS_UNKNOWN};
  logic        gate_prev_q [2] = '{default: 1'b0};
  logic        arm_q [2] = '{default: 1'b0};
  logic        out_q [2] = '{default: 1'b0};
  logic        pend_q [2] = '{default: 1'b0};
  level_t      thr_low = LOW_THRESHOLD_RST;
  level_t      thr_high = HIGH_THRESHOLD_RST;

  result_t     expected_results [$];
  int          mismatch_count = 0;
  int          send_idle_pct = 30;
  int          recv_idle_pct = 60;
  logic        stall_request = 1'b0;
  string       field_names [4] = '{"armed_two", "armed_one", "out_two_high", "out_one_high"};

  // Advances one Schmitt trigger and tells whether it rose from low to high.
  function automatic logic schmitt_rises(int which, level_t level);
    trig_state_t now;
    now = trig_q[which];
    if (now == TS_HIGH) begin
      if (level <= thr_low) trig_q[which] = TS_LOW;
      return 1'b0;
    end
    if (level >= thr_high) begin
      trig_q[which] = TS_HIGH;
      return now == TS_LOW;
    end
    if (level <= thr_low) trig_q[which] = TS_LOW;
    return 1'b0;
  endfunction

  function automatic void settle_channel(int ch, logic gate, logic last);
    if (gate) begin
      out_q[ch] = arm_q[ch];
    end else if (out_q[ch]) begin
      arm_q[ch] = 1'b0;
      out_q[ch] = 1'b0;
    end
    // An arm edge seen during a high gate takes effect on the gate's falling edge.
    if (pend_q[ch] && last && !gate) begin
      arm_q[ch] = 1'b1;
      pend_q[ch] = 1'b0;
    end
  endfunction

  function automatic result_t gate_buffer_outputs(tick_t t);
    logic last1, last2, g1, g2;
    last1 = gate_prev_q[0];
    last2 = gate_prev_q[1];
    if (t.gate_one_con) void'(schmitt_rises(TRIG_GATE1, t.gate_one));
    g1 = trig_q[TRIG_GATE1] == TS_HIGH;
    if (t.gate_two_con) begin
      void'(schmitt_rises(TRIG_GATE2, t.gate_two));
      g2 = trig_q[TRIG_GATE2] == TS_HIGH;
    end else begin
      g2 = g1;
    end
    if (!t.arm_one_con) begin
      arm_q[0] = 1'b0;
    end else if (schmitt_rises(TRIG_ARM1, t.arm_one)) begin
      if (g1) pend_q[0] = 1'b1;
      else arm_q[0] = 1'b1;
    end
    settle_channel(0, g1, last1);
    if (!t.arm_two_con) begin
      arm_q[1] = arm_q[0];
    end else if (schmitt_rises(TRIG_ARM2, t.arm_two)) begin
      if (g2) pend_q[1] = 1'b1;
      else arm_q[1] = 1'b1;
    end
    settle_channel(1, g2, last2);
    gate_prev_q[0] = g1;
    gate_prev_q[1] = g2;
    return '{out_q[0], out_q[1], arm_q[0], arm_q[1]};
  endfunction

  // Levels cluster around the thresholds and the rails, and often repeat, so that
  // gates and arms stay put for a few ticks and edges follow one another.
  function automatic level_t random_level(level_t prev);
    int unsigned pick;
    int          v;
    pick = $urandom_range(99);
    if (pick < 45) return prev;
    if (pick < 62) v = int'(thr_low) + int'($urandom_range(4)) - 2;
    else if (pick < 79) v = int'(thr_high) + int'($urandom_range(4)) - 2;
    else if (pick < 83) v = -32768;
    else if (pick < 87) v = 32767;
    else v = int'(level_t'($urandom));
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return level_t'(v);
  endfunction

  task automatic report_problem(string msg);
    mismatch_count++;
    if (mismatch_count <= 40) $display("[%0t] %s", $time, msg);
  endtask

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic send_tick(tick_t t, logic typed, result_t want);
    result_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid              <= 1'b1;
    in_ch.arm_one_level      <= t.arm_one;
    in_ch.gate_one_level     <= t.gate_one;
    in_ch.arm_two_level      <= t.arm_two;
    in_ch.gate_two_level     <= t.gate_two;
    in_ch.arm_one_connected  <= t.arm_one_con;
    in_ch.gate_one_connected <= t.gate_one_con;
    in_ch.arm_two_connected  <= t.arm_two_con;
    in_ch.gate_two_connected <= t.gate_two_con;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    predicted = gate_buffer_outputs(t);
    expected_results.push_back(typed ? want : predicted);
    @(negedge clk);
  endtask

  task automatic write_threshold(cfg_reg_t idx, level_t value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    if (idx == REG_LOW_THRESHOLD) thr_low = value;
    else thr_high = value;
    @(negedge clk);
  endtask

  task automatic wait_until_drained();
    do @(negedge clk); while (expected_results.size() != 0);
  endtask

  initial begin : receiver
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_request) begin
        // Long hold-off so the block fills up and drops in_ch.ready.
        out_ch.ready <= 1'b0;
        repeat (LONG_STALL - 1) @(negedge clk);
        stall_request = 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin : result_check
    result_t got;
    result_t want;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        got = '{out_ch.out_one_high, out_ch.out_two_high, out_ch.armed_one, out_ch.armed_two};
        if (expected_results.size() == 0) begin
          report_problem($sformatf("result %b arrived with nothing expected", got));
        end else begin
          want = expected_results.pop_front();
          for (int b = 0; b < 4; b++) begin
            if (got[b] !== want[b])
              report_problem($sformatf("%s is %b, expected %b",
                                       field_names[b], got[b], want[b]));
          end
        end
      end
    end
  end

  initial begin : watchdog
    #2_000_000;
    $display("dual_armed_gate_buffer_test NOT OK");
    $finish;
  end

  initial begin : stimulus
    tick_t  t;
    phase_t p;
    level_t lv [4];
    rst_n                    = 1'b0;
    in_ch.valid              = 1'b0;
    in_ch.arm_one_level      = '0;
    in_ch.gate_one_level     = '0;
    in_ch.arm_two_level      = '0;
    in_ch.gate_two_level     = '0;
    in_ch.arm_one_connected  = 1'b0;
    in_ch.gate_one_connected = 1'b0;
    in_ch.arm_two_connected  = 1'b0;
    in_ch.gate_two_connected = 1'b0;
    cfg_ch.valid             = 1'b0;
    cfg_ch.index             = REG_LOW_THRESHOLD;
    cfg_ch.data              = '0;
    lv = '{default: '0};
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    foreach (DIRECTED_ROWS[r])
      send_tick(DIRECTED_ROWS[r].tick, DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].want);

    foreach (PHASES[ph]) begin
      p = PHASES[ph];
      in_ch.valid <= 1'b0;
      wait_until_drained();
      write_threshold(REG_LOW_THRESHOLD, p.lo);
      write_threshold(REG_HIGH_THRESHOLD, p.hi);
      cfg_ch.valid <= 1'b0;
      send_idle_pct = p.send_idle;
      recv_idle_pct = p.recv_idle;
      for (int i = 0; i < p.count; i++) begin
        if (p.long_stall && i == 40) stall_request = 1'b1;
        if (p.mid_drain && i == p.count / 2) begin
          in_ch.valid <= 1'b0;
          wait_until_drained();
        end
        foreach (lv[k]) lv[k] = random_level(lv[k]);
        t = '{lv[0], lv[1], lv[2], lv[3],
              $urandom_range(99) < 88, $urandom_range(99) < 88,
              $urandom_range(99) < 88, $urandom_range(99) < 88};
        send_tick(t, 1'b0, '0);
      end
    end

    in_ch.valid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("dual_armed_gate_buffer_test OK");
    end else begin
      $display("dual_armed_gate_buffer_test NOT OK");
    end
    $finish;
  end

endmodule
